### rtl/tsnps_pkg.sv
// Shared types, constants and codes of the null packet stuffing scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tsnps_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned TICKS_W    = 40;
    localparam int unsigned PKTCNT_W   = 20;
    localparam int unsigned STUFF_W    = 32;
    localparam int unsigned CARRY_W    = 11;
    localparam int unsigned HI_W       = 41;
    localparam int unsigned LO_W       = 72;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_SEGMENT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEG_PACKET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEG_END     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INIT_PACKET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINAL_PACKET = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NO_SEGMENT  = 3'd5;

    localparam logic [2:0] REG_OUT_BITRATE    = 3'd0;
    localparam logic [2:0] REG_INITIAL_SHARE  = 3'd1;
    localparam logic [2:0] REG_FINAL_SHARE    = 3'd2;
    localparam logic [2:0] REG_USE_MEAS_INIT  = 3'd3;
    localparam logic [2:0] REG_USE_MEAS_FINAL = 3'd4;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [HI_W-1:0] CLOCK_HZ    = 41'd27000000;
    localparam logic [HI_W-1:0] PACKET_BITS = 41'd1504;
    localparam logic [24:0]     MAX_SEGMENT_PACKETS = 25'd1048576;

    localparam logic [STEP_W-1:0] MUL_STEPS   = 6'd32;
    localparam logic [STEP_W-1:0] DIV_T_STEPS = 6'd48;
    localparam logic [STEP_W-1:0] DIV_P_STEPS = 6'd39;
    localparam logic [STEP_W-1:0] DIV_S_STEPS = 6'd32;

    typedef struct packed {
        logic [31:0] out_bitrate;
        logic [15:0] initial_share;
        logic [15:0] final_share;
        logic        use_measured_initial;
        logic        use_measured_final;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [STEP_W-1:0] steps;
        logic [HI_W-1:0]   hi;
        logic [LO_W-1:0]   lo;
        logic [HI_W-1:0]   operand;
    } t_unit_req;

    typedef struct packed {
        logic            done;
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
    } t_unit_res;

endpackage
`default_nettype wire

### rtl/tsnps_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface tsnps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [39:0] duration_ticks;
    logic [19:0] packet_count;

    modport source (output valid, command, duration_ticks, packet_count, input ready);
    modport sink (input valid, command, duration_ticks, packet_count, output ready);
endinterface

interface tsnps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] stuffing_count;
    logic        rate_exceeded;

    modport source (output valid, stuffing_count, rate_exceeded, input ready);
    modport sink (input valid, stuffing_count, rate_exceeded, output ready);
endinterface
`default_nettype wire

### rtl/tsnps_cfg.sv
// APB register file holding the bitrate and share settings.
`timescale 1ns / 1ps
`default_nettype none
module tsnps_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tsnps_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tsnps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tsnps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output tsnps_pkg::t_cfg                          o_cfg
);

    tsnps_pkg::t_cfg r_cfg;
    tsnps_pkg::t_cfg n_cfg;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                tsnps_pkg::REG_OUT_BITRATE:    n_cfg.out_bitrate = pwdata;
                tsnps_pkg::REG_INITIAL_SHARE:  n_cfg.initial_share = pwdata[15:0];
                tsnps_pkg::REG_FINAL_SHARE:    n_cfg.final_share = pwdata[15:0];
                tsnps_pkg::REG_USE_MEAS_INIT:  n_cfg.use_measured_initial = pwdata[0];
                tsnps_pkg::REG_USE_MEAS_FINAL: n_cfg.use_measured_final = pwdata[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tsnps_pkg::REG_OUT_BITRATE:    prdata = r_cfg.out_bitrate;
            tsnps_pkg::REG_INITIAL_SHARE:  prdata = {16'd0, r_cfg.initial_share};
            tsnps_pkg::REG_FINAL_SHARE:    prdata = {16'd0, r_cfg.final_share};
            tsnps_pkg::REG_USE_MEAS_INIT:  prdata = {31'd0, r_cfg.use_measured_initial};
            tsnps_pkg::REG_USE_MEAS_FINAL: prdata = {31'd0, r_cfg.use_measured_final};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_bitrate          <= 32'd1;
            r_cfg.initial_share        <= 16'd0;
            r_cfg.final_share          <= 16'd0;
            r_cfg.use_measured_initial <= 1'b1;
            r_cfg.use_measured_final   <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

### rtl/tsnps_unit.sv
// Shared iterative unit: shift-add multiplier and restoring divider on one adder.
`timescale 1ns / 1ps
`default_nettype none
module tsnps_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tsnps_pkg::t_unit_req  i_req,
    output tsnps_pkg::t_unit_res       o_res
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic                           r_op, n_op;
    logic [tsnps_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic [tsnps_pkg::HI_W-1:0]     r_hi, n_hi;
    logic [tsnps_pkg::LO_W-1:0]     r_lo, n_lo;
    logic [tsnps_pkg::HI_W-1:0]     r_b, n_b;
    logic [tsnps_pkg::HI_W-1:0]     add_a;
    logic [tsnps_pkg::HI_W-1:0]     add_b;
    logic [tsnps_pkg::HI_W:0]       sum;
    logic                           is_div;

    assign is_div = (r_op == tsnps_pkg::OP_DIV);
    assign add_a  = is_div ? {r_hi[39:0], r_lo[71]} : r_hi;
    assign add_b  = is_div ? ~r_b : r_b;
    assign sum    = {1'b0, add_a} + {1'b0, add_b} + {41'd0, is_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_b    = r_b;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = i_req.steps;
            n_hi   = i_req.hi;
            n_lo   = i_req.lo;
            n_b    = i_req.operand;
        end else if (r_busy) begin
            n_cnt  = r_cnt - 6'd1;
            n_busy = (r_cnt != 6'd1);
            n_done = (r_cnt == 6'd1);
            if (is_div) begin
                n_hi = sum[41] ? sum[40:0] : add_a;
                n_lo = {r_lo[70:0], sum[41]};
            end else if (r_lo[0]) begin
                n_hi = sum[41:1];
                n_lo = {sum[0], r_lo[71:1]};
            end else begin
                n_hi = {1'b0, r_hi[40:1]};
                n_lo = {r_hi[0], r_lo[71:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= tsnps_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_b  <= n_b;
    end

    assign o_res.done = r_done;
    assign o_res.hi   = r_hi;
    assign o_res.lo   = r_lo;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("A new operation was started while the unit was busy.");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && is_div |-> r_hi < r_b)
        else $error("The partial remainder reached the divisor.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("Completion was flagged without a finished operation.");

endmodule
`default_nettype wire

### rtl/ts_null_packet_stuffing_scheduler.sv
// Top level of the constant-bitrate null packet stuffing scheduler.
//
//  Channel  Dir  Handshake          Payload
//  i_in     in   valid/ready        command, duration_ticks, packet_count
//  o_out    out  valid/ready        stuffing_count, rate_exceeded
//  APB      in   psel/penable       paddr, pwdata, prdata (pready always high)
//
// A segment result is built in steps after acceptance: a load of the shared adder before each run
// (a 32-step multiply, then divides of 48, 39 and 32 steps), a store of the share and the placing
// of the result. A flagged segment skips the last divide.
// Every other command places its result at the accepting edge, so it is valid in the next cycle.
// Synchronous active-low reset clears the segment state and loads register defaults.
// A stalled output holds the result, and no new item is taken until it can be placed.
`timescale 1ns / 1ps
`default_nettype none
module ts_null_packet_stuffing_scheduler #(
    parameter logic [24:0] MAX_SEG_PACKETS = tsnps_pkg::MAX_SEGMENT_PACKETS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tsnps_in_if.sink                               i_in,
    tsnps_out_if.source                            o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tsnps_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tsnps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tsnps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DIV_T  = 3'd2;
    localparam logic [2:0] S_DIV_P  = 3'd3;
    localparam logic [2:0] S_DIV_S  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    tsnps_pkg::t_cfg       cfg;
    tsnps_pkg::t_unit_req  unit_req;
    tsnps_pkg::t_unit_res  unit_res;

    logic [2:0]   r_state, n_state;
    logic [19:0]  r_count, n_count;
    logic         r_flag, n_flag;
    logic [31:0]  r_share, n_share;
    logic [19:0]  r_residue, n_residue;
    logic [31:0]  r_remaining, n_remaining;
    logic [10:0]  r_carry, n_carry;
    logic         r_out_valid, n_out_valid;
    logic [31:0]  r_out_stuff, n_out_stuff;
    logic         r_out_flag, n_out_flag;

    logic         out_free;
    logic         accept;
    logic [71:0]  product;
    logic [48:0]  tbits;
    logic [39:0]  pkt_diff;
    logic [31:0]  rem_sat;
    logic         exceed;
    logic         res_bit;
    logic [32:0]  pkt_want;
    logic [31:0]  pkt_stuff;

    tsnps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tsnps_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_res   (unit_res)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign product  = {unit_res.hi[39:0], unit_res.lo[71:40]};
    assign tbits    = {1'b0, unit_res.lo[47:0]} + {38'd0, r_carry};
    assign pkt_diff = {1'b0, unit_res.lo[38:0]} - {20'd0, r_count};
    assign rem_sat  = (pkt_diff[38:32] != 7'd0) ? 32'hFFFF_FFFF : pkt_diff[31:0];
    assign exceed   = (r_count == 20'd0) || ({5'd0, r_count} > MAX_SEG_PACKETS)
                      || pkt_diff[39];

    assign res_bit   = (r_residue != 20'd0);
    assign pkt_want  = {1'b0, r_share} + {32'd0, res_bit};
    assign pkt_stuff = (pkt_want > {1'b0, r_remaining}) ? r_remaining : pkt_want[31:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_flag      = r_flag;
        n_share     = r_share;
        n_residue   = r_residue;
        n_remaining = r_remaining;
        n_carry     = r_carry;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_stuff = r_out_stuff;
        n_out_flag  = r_out_flag;
        unit_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_stuff = '0;
                    n_out_flag  = 1'b0;
                    unique case (i_in.command)
                        tsnps_pkg::CMD_SEGMENT: begin
                            n_count          = i_in.packet_count;
                            n_state          = S_MUL;
                            unit_req.start   = 1'b1;
                            unit_req.op      = tsnps_pkg::OP_MUL;
                            unit_req.steps   = tsnps_pkg::MUL_STEPS;
                            unit_req.hi      = '0;
                            unit_req.lo      = {40'd0, cfg.out_bitrate};
                            unit_req.operand = {1'b0, i_in.duration_ticks};
                        end
                        tsnps_pkg::CMD_SEG_PACKET: begin
                            n_out_valid = 1'b1;
                            n_out_stuff = pkt_stuff;
                            n_remaining = r_remaining - pkt_stuff;
                            n_residue   = r_residue - {19'd0, res_bit};
                        end
                        tsnps_pkg::CMD_SEG_END: begin
                            n_out_valid = 1'b1;
                            n_out_stuff = r_remaining;
                            n_remaining = '0;
                        end
                        tsnps_pkg::CMD_INIT_PACKET: begin
                            n_out_valid = 1'b1;
                            n_out_stuff = cfg.use_measured_initial ? r_share
                                          : {16'd0, cfg.initial_share};
                        end
                        tsnps_pkg::CMD_FINAL_PACKET: begin
                            n_out_valid = 1'b1;
                            n_out_stuff = cfg.use_measured_final ? r_share
                                          : {16'd0, cfg.final_share};
                        end
                        tsnps_pkg::CMD_NO_SEGMENT: begin
                            n_out_valid = 1'b1;
                            n_remaining = '0;
                            n_residue   = '0;
                            n_carry     = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (unit_res.done) begin
                    n_state          = S_DIV_T;
                    unit_req.start   = 1'b1;
                    unit_req.op      = tsnps_pkg::OP_DIV;
                    unit_req.steps   = tsnps_pkg::DIV_T_STEPS;
                    unit_req.hi      = {17'd0, product[71:48]};
                    unit_req.lo      = {product[47:0], 24'd0};
                    unit_req.operand = tsnps_pkg::CLOCK_HZ;
                end
            end
            S_DIV_T: begin
                if (unit_res.done) begin
                    n_state          = S_DIV_P;
                    unit_req.start   = 1'b1;
                    unit_req.op      = tsnps_pkg::OP_DIV;
                    unit_req.steps   = tsnps_pkg::DIV_P_STEPS;
                    unit_req.hi      = {31'd0, tbits[48:39]};
                    unit_req.lo      = {tbits[38:0], 33'd0};
                    unit_req.operand = tsnps_pkg::PACKET_BITS;
                end
            end
            S_DIV_P: begin
                if (unit_res.done) begin
                    if (exceed) begin
                        n_flag      = 1'b1;
                        n_share     = '0;
                        n_residue   = '0;
                        n_remaining = '0;
                        n_carry     = '0;
                        n_state     = S_FIN;
                    end else begin
                        n_flag           = 1'b0;
                        n_remaining      = rem_sat;
                        n_carry          = unit_res.hi[10:0];
                        n_state          = S_DIV_S;
                        unit_req.start   = 1'b1;
                        unit_req.op      = tsnps_pkg::OP_DIV;
                        unit_req.steps   = tsnps_pkg::DIV_S_STEPS;
                        unit_req.hi      = '0;
                        unit_req.lo      = {rem_sat, 40'd0};
                        unit_req.operand = {21'd0, r_count};
                    end
                end
            end
            S_DIV_S: begin
                if (unit_res.done) begin
                    n_share   = unit_res.lo[31:0];
                    n_residue = unit_res.hi[19:0];
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stuff = '0;
                    n_out_flag  = r_flag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flag      <= 1'b0;
            r_share     <= '0;
            r_residue   <= '0;
            r_remaining <= '0;
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_share     <= n_share;
            r_residue   <= n_residue;
            r_remaining <= n_remaining;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count     <= n_count;
        r_out_stuff <= n_out_stuff;
        r_out_flag  <= n_out_flag;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.stuffing_count = r_out_stuff;
    assign o_out.rate_exceeded  = r_out_flag;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE)
        else $error("An item was offered acceptance while a segment was in progress.");

    a_unit_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_res.done |-> r_state != S_IDLE && r_state != S_FIN)
        else $error("The shared unit finished while no segment was in progress.");

    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && !r_flag |-> r_count != 20'd0)
        else $error("A segment with no packets was not flagged.");

    a_flag_segment_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_out_flag |-> $past(r_state) == S_FIN)
        else $error("The rate flag was raised outside a segment result.");

endmodule
`default_nettype wire
